>>> hw/rtl/ippr_pkg.sv
// Package for the IR pulse-position receiver: word types, codes, bit windows.
package ippr_pkg;

    // Item codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_RX_TICK  = 2'd0,
        KIND_PER_TICK = 2'd1,
        KIND_EDGE     = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    // Input word
    typedef struct packed {
        logic [1:0] kind;
        logic       rising;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic        message_valid;
        logic [7:0]  message;
        logic [7:0]  pulse_distance;
        logic [15:0] arrival_period;
        logic        frame_aborted;
        logic        in_frame;
        logic        success_lamp;
    } t_out_word;

    // Window lookup result
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_win;

    localparam logic [7:0] TIMEOUT_RESET = 8'd200;
    localparam logic [7:0] START_BYTE    = 8'h80;
    localparam logic [7:0] BIT6_MASK     = 8'h40;
    localparam logic [7:0] BIT0_MASK     = 8'h01;
    localparam int         NUM_WIN       = 7;
    localparam logic [2:0] LAST_WIN      = 3'd6;

    // Inclusive receive-count windows, bit 6 first, bit 0 last
    localparam logic [7:0] WIN_LO [NUM_WIN] = '{8'd10, 8'd22, 8'd35, 8'd47,
                                                8'd60, 8'd72, 8'd85};
    localparam logic [7:0] WIN_HI [NUM_WIN] = '{8'd17, 8'd29, 8'd42, 8'd54,
                                                8'd67, 8'd79, 8'd92};

    // Find the window holding a receive count (windows do not overlap)
    function automatic t_win win_lookup(input logic [7:0] count);
        t_win w;
        w.hit = 1'b0;
        w.idx = '0;
        for (int i = NUM_WIN - 1; i >= 0; i--) begin
            if (count >= WIN_LO[i] && count <= WIN_HI[i]) begin
                w.hit = 1'b1;
                w.idx = 3'(i);
            end
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/ippr_core.sv
// Receiver state and per-word decode: one word in, one result word out.
module ippr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ippr_pkg::t_in_word  i_word,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output ippr_pkg::t_out_word o_result
);
    import ippr_pkg::*;

    logic [7:0]  r_timeout;
    logic        r_receiving, n_receiving;
    logic        r_expect_falling, n_expect_falling;
    logic [7:0]  r_shift_byte, n_shift_byte;
    logic [7:0]  r_rx_count, n_rx_count;
    logic [15:0] r_period_count, n_period_count;
    logic [7:0]  r_distance, n_distance;
    logic [7:0]  r_last_message, n_last_message;
    logic [15:0] r_last_arrival, n_last_arrival;
    logic        r_lamp, n_lamp;
    logic        valid, aborted;
    logic [7:0]  rx_inc;
    t_win        win;

    assign rx_inc = r_rx_count + 8'd1;
    assign win    = win_lookup(r_rx_count);

    // Next state for one word
    always_comb begin
        n_receiving      = r_receiving;
        n_expect_falling = r_expect_falling;
        n_shift_byte     = r_shift_byte;
        n_rx_count       = r_rx_count;
        n_period_count   = r_period_count;
        n_distance       = r_distance;
        n_last_message   = r_last_message;
        n_last_arrival   = r_last_arrival;
        n_lamp           = r_lamp;
        valid            = 1'b0;
        aborted          = 1'b0;
        case (t_kind'(i_word.kind))
            KIND_RX_TICK: begin
                n_rx_count = rx_inc;
                if (rx_inc == r_timeout) begin
                    aborted      = r_receiving;
                    n_receiving  = 1'b0;
                    n_shift_byte = '0;
                    n_rx_count   = '0;
                    n_lamp       = 1'b0;
                end
            end
            KIND_PER_TICK: begin
                n_period_count = r_period_count + 16'd1;
            end
            KIND_EDGE: begin
                if (i_word.rising != r_expect_falling) begin
                    if (!r_receiving) begin
                        // frame start
                        n_rx_count       = '0;
                        n_receiving      = 1'b1;
                        n_shift_byte     = START_BYTE;
                        n_expect_falling = 1'b1;
                        n_lamp           = 1'b0;
                    end else if (r_expect_falling) begin
                        n_distance       = r_rx_count;
                        n_expect_falling = 1'b0;
                    end else if (!win.hit) begin
                        // edge outside every window
                        n_receiving  = 1'b0;
                        n_rx_count   = '0;
                        n_shift_byte = '0;
                        aborted      = 1'b1;
                    end else if (win.idx != LAST_WIN) begin
                        n_shift_byte = r_shift_byte | (BIT6_MASK >> win.idx);
                    end else begin
                        // bit 0 window completes the frame
                        n_last_message = r_shift_byte | BIT0_MASK;
                        n_last_arrival = r_period_count;
                        n_period_count = '0;
                        n_lamp         = 1'b1;
                        valid          = 1'b1;
                        n_receiving    = 1'b0;
                        n_rx_count     = '0;
                        n_shift_byte   = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result word from the updated state
    always_comb begin
        o_result.message_valid  = valid;
        o_result.message        = n_last_message;
        o_result.pulse_distance = n_distance;
        o_result.arrival_period = n_last_arrival;
        o_result.frame_aborted  = aborted;
        o_result.in_frame       = n_receiving;
        o_result.success_lamp   = n_lamp;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout        <= TIMEOUT_RESET;
            r_receiving      <= 1'b0;
            r_expect_falling <= 1'b0;
            r_shift_byte     <= '0;
            r_rx_count       <= '0;
            r_period_count   <= '0;
            r_distance       <= '0;
            r_last_message   <= '0;
            r_last_arrival   <= '0;
            r_lamp           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_accept) begin
                r_receiving      <= n_receiving;
                r_expect_falling <= n_expect_falling;
                r_shift_byte     <= n_shift_byte;
                r_rx_count       <= n_rx_count;
                r_period_count   <= n_period_count;
                r_distance       <= n_distance;
                r_last_message   <= n_last_message;
                r_last_arrival   <= n_last_arrival;
                r_lamp           <= n_lamp;
            end
        end
    end

`ifndef SYNTH
    // Idle means an empty shift byte
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> r_shift_byte == '0)
        else $error("shift byte not clear while idle");
    // A frame in progress always carries the start bit
    a_start_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_receiving |-> r_shift_byte[7])
        else $error("frame lost its start bit");
    // Completion and discard are exclusive
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(valid && aborted))
        else $error("frame both completed and discarded");
    // A completed message ends in bit 0 and lights the lamp
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && valid) |=> (r_last_message[0] && r_lamp && !r_receiving))
        else $error("completion did not update message state");
`endif
endmodule

>>> hw/rtl/ippr_out_buf.sv
// Two-entry result buffer so input keeps flowing while a result waits.
module ippr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  ippr_pkg::t_out_word i_word,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output ippr_pkg::t_out_word o_word
);
    import ippr_pkg::*;

    t_out_word  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       rd;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign rd      = o_valid && !i_stall;
    assign o_word  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_wr, rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    // Never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("write into full result buffer");
    // Count never exceeds depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");
    // Pointers agree with the fill count
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("result buffer pointers inconsistent");
`endif
endmodule

>>> hw/rtl/ir_pulse_position_receiver_top.sv
// Top level of the IR pulse-position receiver.
//
//  channel  direction  handshake                  word
//  in       input      i_in_valid / o_in_stall    i_in_word  (kind, rising)
//  out      output     o_out_valid / i_out_stall  o_out_word (7 result fields)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (timeout_count)
//
// One word is accepted per cycle while the input is not stalled; its result is
// decoded in one pass through the window compares and state update, written to
// the result buffer at the accepting edge, and offered after older results.
// A two-entry result buffer lets input continue while one result waits; the
// input stalls only when both entries are held.
// Synchronous active-low reset clears all state; timeout_count resets to 200.
// Configuration writes are always ready and take effect the next cycle.
module ir_pulse_position_receiver_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ippr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ippr_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import ippr_pkg::*;

    logic      accept;
    logic      buf_full;
    t_out_word result;

    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full;
    assign o_cfg_ready = 1'b1;

    // Decode and state
    ippr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    // Result buffer
    ippr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_word  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );
endmodule
